### hdl/aefd_pkg.sv
// ----------------------------------------------------------------------------
// aefd_pkg: shared types and constants for the echo / flanger delay line
// Sample and store geometry, register indexes, effect modes, divide constants.
// ----------------------------------------------------------------------------
package aefd_pkg;

    // STORE_DEPTH must be a power of two
    localparam int SAMPLE_BITS    = 16;
    localparam int STORE_DEPTH    = 65536;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);

    localparam int DELAY_BITS     = 10;
    localparam int WEIGHT_BITS    = 7;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    localparam int STEP_SHIFT     = 7;
    localparam int BACK_BITS      = DELAY_BITS + STEP_SHIFT;
    localparam int EXT_BITS       = (ADDR_BITS > BACK_BITS) ? ADDR_BITS : BACK_BITS;

    localparam int PROD_BITS      = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int MAG_BITS       = SAMPLE_BITS + 6;
    localparam int RECIP_SHIFT    = MAG_BITS + 7;
    localparam int RECIP_BITS     = RECIP_SHIFT - 6;
    localparam int QUOT_BITS      = MAG_BITS + RECIP_BITS;

    localparam logic [63:0] RECIP_WIDE = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_WIDE[RECIP_BITS-1:0];

    localparam logic [WEIGHT_BITS-1:0] FULL_PERCENT = WEIGHT_BITS'(100);

    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_STEPS    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHT_PERCENT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EFFECT_MODE    = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_BYPASS  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FLANGER = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_ECHO    = 2'd2;

    localparam logic [DELAY_BITS-1:0]  DELAY_RESET  = 10'd1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 7'd1;
    localparam logic [MODE_BITS-1:0]   MODE_RESET   = MODE_BYPASS;

    typedef struct packed {
        logic                          en;
        logic [ADDR_BITS-1:0]          addr;
        logic signed [SAMPLE_BITS-1:0] data;
    } store_wr_t;

endpackage

### hdl/aefd_store.sv
// ----------------------------------------------------------------------------
// aefd_store: circular sample history
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aefd_store
(
    input  logic                                  clk,
    input  logic                                  rd_en,
    input  logic [aefd_pkg::ADDR_BITS-1:0]        rd_addr,
    output logic signed [aefd_pkg::SAMPLE_BITS-1:0] rd_data,
    input  aefd_pkg::store_wr_t                   wr
);
    import aefd_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem_array [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/audio_echo_flanger_delay.sv
// ----------------------------------------------------------------------------
// audio_echo_flanger_delay: feedback echo / flanger delay line
// Mixes each sample with one read from a circular history, percent weighted.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    dry_sample
//   out      source     out_valid / out_stall  wet_sample
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle while out_stall is low; input passes s1, s2, s3 and the
// output register (history read, two products, magnitude, reciprocal divide).
// Reset clears control state only; the history needs no clearing pass: slots
// not yet reached in the first lap read as zero, and bypass writes zero there.
// A stalled output fills the three inner stages before in_stall rises.
// ----------------------------------------------------------------------------
module audio_echo_flanger_delay
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic signed [aefd_pkg::SAMPLE_BITS-1:0]    dry_sample,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [aefd_pkg::SAMPLE_BITS-1:0]    wet_sample,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [aefd_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [aefd_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
    import aefd_pkg::*;

    logic [DELAY_BITS-1:0]  delay_steps_reg;
    logic [WEIGHT_BITS-1:0] weight_percent_reg;
    logic [MODE_BITS-1:0]   effect_mode_reg;

    logic [ADDR_BITS-1:0]   wp_reg;
    logic [ADDR_BITS-1:0]   wp_next;
    logic                   lap_done_reg;
    logic                   lap_done_next;

    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    logic                   out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] s1_dry_reg;
    logic [ADDR_BITS-1:0]          s1_wp_reg;
    logic                          s1_live_reg;
    logic                          s1_fresh_reg;

    logic signed [PROD_BITS-1:0]   s2_p_dry_reg;
    logic signed [PROD_BITS-1:0]   s2_p_del_reg;
    logic signed [PROD_BITS-1:0]   s2_p_dry_next;
    logic signed [PROD_BITS-1:0]   s2_p_del_next;
    logic signed [SAMPLE_BITS-1:0] s2_dry_reg;
    logic [ADDR_BITS-1:0]          s2_wp_reg;
    logic                          s2_fresh_reg;

    logic [MAG_BITS-1:0]           s3_mag_reg;
    logic [MAG_BITS-1:0]           s3_mag_next;
    logic                          s3_neg_reg;
    logic signed [SAMPLE_BITS-1:0] s3_dry_reg;
    logic [ADDR_BITS-1:0]          s3_wp_reg;
    logic                          s3_fresh_reg;

    logic signed [SAMPLE_BITS-1:0] wet_reg;
    logic signed [SAMPLE_BITS-1:0] wet_next;

    logic                   accept;
    logic                   load2;
    logic                   load3;
    logic                   load_out;
    logic                   free1;
    logic                   free2;
    logic                   free3;

    logic [EXT_BITS-1:0]    back_ext;
    logic [ADDR_BITS-1:0]   back;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   rd_live;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] delayed;

    logic [WEIGHT_BITS-1:0] w_del;
    logic [WEIGHT_BITS-1:0] w_dry;
    logic signed [PROD_BITS-1:0] sum;
    logic signed [PROD_BITS-1:0] mag_full;
    logic [QUOT_BITS-1:0]   quot_full;
    logic [SAMPLE_BITS-1:0] quot;
    logic signed [SAMPLE_BITS-1:0] mixed;

    store_wr_t              wr;

    // handshake and stage advance
    assign load_out  = s3_valid_reg && (!out_valid_reg || !out_stall);
    assign free3     = !s3_valid_reg || load_out;
    assign load3     = s2_valid_reg && free3;
    assign free2     = !s2_valid_reg || load3;
    assign load2     = s1_valid_reg && free2;
    assign free1     = !s1_valid_reg || load2;
    assign in_stall  = !free1;
    assign accept    = in_valid && free1;
    assign out_valid = out_valid_reg;
    assign wet_sample = wet_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_steps_reg    <= DELAY_RESET;
            weight_percent_reg <= WEIGHT_RESET;
            effect_mode_reg    <= MODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DELAY_STEPS:    delay_steps_reg    <= cfg_data[DELAY_BITS-1:0];
                REG_WEIGHT_PERCENT: weight_percent_reg <= cfg_data[WEIGHT_BITS-1:0];
                REG_EFFECT_MODE:    effect_mode_reg    <= cfg_data[MODE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // read address and first-lap qualification
    assign back_ext = EXT_BITS'({delay_steps_reg, {STEP_SHIFT{1'b0}}});
    assign back     = back_ext[ADDR_BITS-1:0];
    assign rd_addr  = wp_reg - back;
    assign rd_live  = lap_done_reg || (rd_addr < wp_reg);

    assign wp_next       = accept ? wp_reg + 1'b1 : wp_reg;
    assign lap_done_next = lap_done_reg || (accept && (wp_reg == '1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            lap_done_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            lap_done_reg  <= lap_done_next;
            s1_valid_reg  <= accept || (s1_valid_reg && !load2);
            s2_valid_reg  <= load2 || (s2_valid_reg && !load3);
            s3_valid_reg  <= load3 || (s3_valid_reg && !load_out);
            out_valid_reg <= load_out || (out_valid_reg && out_stall);
        end
    end

    aefd_store u_store
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dry_reg   <= dry_sample;
            s1_wp_reg    <= wp_reg;
            s1_live_reg  <= rd_live;
            s1_fresh_reg <= !lap_done_reg;
        end
    end

    // weighted products
    assign w_del   = (weight_percent_reg > FULL_PERCENT) ? FULL_PERCENT : weight_percent_reg;
    assign w_dry   = FULL_PERCENT - w_del;
    assign delayed = s1_live_reg ? rd_data : '0;
    assign s2_p_dry_next = PROD_BITS'(s1_dry_reg) * PROD_BITS'($signed({1'b0, w_dry}));
    assign s2_p_del_next = PROD_BITS'(delayed) * PROD_BITS'($signed({1'b0, w_del}));

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_p_dry_reg <= s2_p_dry_next;
            s2_p_del_reg <= s2_p_del_next;
            s2_dry_reg   <= s1_dry_reg;
            s2_wp_reg    <= s1_wp_reg;
            s2_fresh_reg <= s1_fresh_reg;
        end
    end

    // sum and magnitude
    assign sum         = s2_p_dry_reg + s2_p_del_reg;
    assign mag_full    = sum[PROD_BITS-1] ? -sum : sum;
    assign s3_mag_next = mag_full[MAG_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_mag_reg   <= s3_mag_next;
            s3_neg_reg   <= sum[PROD_BITS-1];
            s3_dry_reg   <= s2_dry_reg;
            s3_wp_reg    <= s2_wp_reg;
            s3_fresh_reg <= s2_fresh_reg;
        end
    end

    // divide by 100 toward zero, then select result and history write
    assign quot_full = QUOT_BITS'(s3_mag_reg) * QUOT_BITS'(RECIP);
    assign quot      = quot_full[RECIP_SHIFT +: SAMPLE_BITS];
    assign mixed     = s3_neg_reg ? $signed(-quot) : $signed(quot);

    always_comb
    begin
        wr.en    = 1'b0;
        wr.addr  = s3_wp_reg;
        wr.data  = '0;
        wet_next = s3_dry_reg;
        case (effect_mode_reg)
            MODE_FLANGER:
            begin
                wr.en    = load_out;
                wr.data  = s3_dry_reg;
                wet_next = mixed;
            end
            MODE_ECHO:
            begin
                wr.en    = load_out;
                wr.data  = mixed;
                wet_next = mixed;
            end
            default:
            begin
                wr.en    = load_out && s3_fresh_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            wet_reg <= wet_next;
        end
    end

    ap_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with first stage empty");

    ap_lap_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (wp_reg == '1)) |=> lap_done_reg)
        else $error("pointer wrapped without marking the lap done");

    ap_lap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        lap_done_reg |=> lap_done_reg)
        else $error("lap done flag dropped");

    ap_lap_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(lap_done_reg) |-> (wp_reg == '0))
        else $error("lap done rose away from pointer wrap");

endmodule

### test/audio_echo_flanger_delay_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_echo_flanger_delay_test: self-checking bench for the echo delay line
// Walks a directed table through reset values, extreme samples and every
// register extreme, then runs randomized phases of register settings and
// samples. Each wet_sample transaction is checked against a table value or a
// local model of the circular history and the percent mix. Random idle bursts
// on both channels, one long output hold-off, and a quiet tail are included.
// ----------------------------------------------------------------------------
module audio_echo_flanger_delay_test;

    import aefd_pkg::*;

    localparam int          OUT_LATENCY = 3;
    localparam int          HOLD_CYCLES = 48;
    localparam int          PHASES      = 12;
    localparam int          PHASE_ITEMS = 112;
    localparam int          REPORT_MAX  = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          TABLE_ROWS  = 31;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE  = 2'd3;
    localparam logic [MODE_BITS-1:0]      MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECK
    } row_op_t;

    typedef struct packed {
        row_op_t                       op;
        logic [CFG_INDEX_BITS-1:0]     reg_index;
        logic [CFG_DATA_BITS-1:0]      reg_data;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [SAMPLE_BITS-1:0] wet;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] dry_sample;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] wet_sample;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    logic signed [SAMPLE_BITS-1:0] history [0:STORE_DEPTH-1];
    logic [ADDR_BITS-1:0]          write_ptr;
    logic [DELAY_BITS-1:0]         shadow_delay;
    logic [WEIGHT_BITS-1:0]        shadow_weight;
    logic [MODE_BITS-1:0]          shadow_mode;

    logic signed [SAMPLE_BITS-1:0] wet_expected [$];
    int                            mismatch_count;
    int unsigned                   cycle_count;
    bit                            gap_on;
    bit                            stall_on;
    bit                            hold_req;

    stim_row_t directed_rows [TABLE_ROWS] = '{
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh7FFF,  16'sh7FFF},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh8000,  16'sh8000},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh0001,  16'sh0001},
        '{ROW_WRITE,  REG_EFFECT_MODE,    10'(MODE_FLANGER), 16'sd0, 16'sd0},
        '{ROW_WRITE,  REG_WEIGHT_PERCENT, 10'd127, 16'sd0,     16'sd0},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh7FFF,  16'sd0},
        '{ROW_WRITE,  REG_WEIGHT_PERCENT, 10'd0,   16'sd0,     16'sd0},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh8000,  16'sh8000},
        '{ROW_WRITE,  REG_EFFECT_MODE,    10'(MODE_SPARE), 16'sd0, 16'sd0},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh1234,  16'sh1234},
        '{ROW_WRITE,  REG_EFFECT_MODE,    10'(MODE_ECHO), 16'sd0, 16'sd0},
        '{ROW_WRITE,  REG_WEIGHT_PERCENT, 10'd50,  16'sd0,     16'sd0},
        '{ROW_WRITE,  REG_DELAY_STEPS,    10'd0,   16'sd0,     16'sd0},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   -16'sd3,    -16'sd1},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh7FFF,  16'sd16383},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh8000,  -16'sd16384},
        '{ROW_WRITE,  REG_DELAY_STEPS,    10'd1023, 16'sd0,    16'sd0},
        '{ROW_WRITE,  REG_WEIGHT_PERCENT, 10'd99,  16'sd0,     16'sd0},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh8000,  -16'sd327},
        '{ROW_CHECK,  REG_DELAY_STEPS,    10'd0,   16'sh7FFF,  16'sd327},
        '{ROW_WRITE,  REG_SPARE,          10'd1023, 16'sd0,    16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   16'sh5A5A,  16'sd0},
        '{ROW_WRITE,  REG_DELAY_STEPS,    10'd900, 16'sd0,     16'sd0},
        '{ROW_WRITE,  REG_WEIGHT_PERCENT, 10'h3E4, 16'sd0,     16'sd0},
        '{ROW_WRITE,  REG_EFFECT_MODE,    10'(MODE_FLANGER), 16'sd0, 16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   16'sh8000,  16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   16'sh7FFF,  16'sd0},
        '{ROW_WRITE,  REG_DELAY_STEPS,    10'd1,   16'sd0,     16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   16'sh0F0F,  16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   -16'sd1,    16'sd0},
        '{ROW_SAMPLE, REG_DELAY_STEPS,    10'd0,   16'sh2A2A,  16'sd0}
    };

    audio_echo_flanger_delay u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .dry_sample (dry_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .wet_sample (wet_sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] echo_mix_predict(
        input logic signed [SAMPLE_BITS-1:0] dry);
        logic [ADDR_BITS-1:0]          back;
        logic [ADDR_BITS-1:0]          rd_ptr;
        logic signed [SAMPLE_BITS-1:0] delayed;
        logic signed [SAMPLE_BITS-1:0] wet;
        int                            w;
        longint                        sum;
        back    = ADDR_BITS'({shadow_delay, 7'b0});
        rd_ptr  = write_ptr - back;
        delayed = history[rd_ptr];
        w       = (shadow_weight > FULL_PERCENT) ? 100 : int'(shadow_weight);
        sum     = longint'(dry) * (100 - w) + longint'(delayed) * w;
        wet     = SAMPLE_BITS'(sum / 100);
        if (shadow_mode == MODE_FLANGER)
        begin
            history[write_ptr] = dry;
        end
        else if (shadow_mode == MODE_ECHO)
        begin
            history[write_ptr] = wet;
        end
        else
        begin
            wet = dry;
        end
        write_ptr = write_ptr + 1'b1;
        return wet;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_DELAY_STEPS:    shadow_delay  = val[DELAY_BITS-1:0];
            REG_WEIGHT_PERCENT: shadow_weight = val[WEIGHT_BITS-1:0];
            REG_EFFECT_MODE:    shadow_mode   = val[MODE_BITS-1:0];
            default:            ;
        endcase
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] dry,
                               input bit typed,
                               input logic signed [SAMPLE_BITS-1:0] typed_wet);
        logic signed [SAMPLE_BITS-1:0] predicted;
        in_valid   <= 1'b1;
        dry_sample <= dry;
        cfg_valid  <= 1'b0;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predicted = echo_mix_predict(dry);
        wet_expected.push_back(typed ? typed_wet : predicted);
    endtask

    task automatic idle_sender();
        if (gap_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (wet_expected.size() != 0) @(posedge clk);
        repeat (OUT_LATENCY + 2) @(posedge clk);
    endtask

    // receiver side: random stall bursts, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : wet_check
        logic signed [SAMPLE_BITS-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (wet_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected wet_sample transaction: %0d", wet_sample);
            end
            else
            begin
                want = wet_expected.pop_front();
                if (wet_sample !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("wet_sample mismatch: expected %0d, got %0d",
                                 want, wet_sample);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int                            phase;
        int                            k;
        int                            pick;
        bit                            prev_write;
        logic signed [SAMPLE_BITS-1:0] s;
        logic [CFG_DATA_BITS-1:0]      d;
        logic [CFG_DATA_BITS-1:0]      wgt;
        logic [MODE_BITS-1:0]          m;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        dry_sample     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        gap_on         = 1'b1;
        stall_on       = 1'b1;
        hold_req       = 1'b0;
        for (k = 0; k < STORE_DEPTH; k++)
            history[k] = '0;
        write_ptr     = '0;
        shadow_delay  = DELAY_RESET;
        shadow_weight = WEIGHT_RESET;
        shadow_mode   = MODE_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_write = 1'b0;
        for (k = 0; k < TABLE_ROWS; k++)
        begin
            case (directed_rows[k].op)
                ROW_WRITE:
                begin
                    if (!prev_write)
                        wait_drain();
                    write_reg(directed_rows[k].reg_index, directed_rows[k].reg_data);
                end
                ROW_CHECK:
                begin
                    send_sample(directed_rows[k].sample, 1'b1, directed_rows[k].wet);
                    idle_sender();
                end
                default:
                begin
                    send_sample(directed_rows[k].sample, 1'b0, '0);
                    idle_sender();
                end
            endcase
            prev_write = (directed_rows[k].op == ROW_WRITE);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drain();

            pick = $urandom_range(0, 9);
            if (pick <= 6)
                d = CFG_DATA_BITS'($urandom_range(1, 8));
            else if (pick == 7)
                d = '0;
            else if (pick == 8)
                d = ($urandom_range(0, 1) == 0) ? 10'd900 : 10'd1023;
            else
                d = CFG_DATA_BITS'($urandom);

            pick = $urandom_range(0, 9);
            if (pick <= 6)
                wgt = CFG_DATA_BITS'($urandom_range(1, 99));
            else if (pick == 7)
                wgt = '0;
            else if (pick == 8)
                wgt = CFG_DATA_BITS'($urandom_range(100, 127));
            else
                wgt = CFG_DATA_BITS'($urandom);

            pick = $urandom_range(0, 9);
            if (pick == 0)
                m = MODE_BYPASS;
            else if (pick == 1)
                m = MODE_SPARE;
            else if (pick <= 5)
                m = MODE_FLANGER;
            else
                m = MODE_ECHO;

            write_reg(REG_DELAY_STEPS, d);
            write_reg(REG_WEIGHT_PERCENT, wgt);
            write_reg(REG_EFFECT_MODE, CFG_DATA_BITS'(m));

            gap_on   = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
            stall_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                gap_on   = 1'b0;
                hold_req = 1'b1;
            end

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 5 && k == PHASE_ITEMS / 2)
                    wait_drain();
                case ($urandom_range(0, 15))
                    0:       s = 16'sh7FFF;
                    1:       s = 16'sh8000;
                    2:       s = '0;
                    3:       s = -16'sd1;
                    default: s = SAMPLE_BITS'($urandom);
                endcase
                send_sample(s, 1'b0, '0);
                idle_sender();
            end
        end

        wait_drain();
        repeat (OUT_LATENCY * 2) @(posedge clk);

        if (mismatch_count == 0 && wet_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### audio_echo_flanger_delay.f
hdl/aefd_pkg.sv
hdl/aefd_store.sv
hdl/audio_echo_flanger_delay.sv
test/audio_echo_flanger_delay_test.sv
